FILE: rtl/ssr_pkg.sv
// shared types and constants for the srrip stream replacement engine
// no dependencies; used by ssr_rrip_alu and ship_srrip_stream_replacement
package ssr_pkg;

  localparam int MODE_W    = 3;
  localparam int SET_IN_W  = 11;
  localparam int WAY_IN_W  = 4;
  localparam int PC_W      = 18;
  localparam int OUT_W     = 8;
  localparam int PC_FOLD_A = 6;
  localparam int PC_FOLD_B = 12;

  localparam logic [1:0] RRPV_MAX   = 2'd3;
  localparam logic [1:0] REUSE_INIT = 2'd1;

  typedef enum logic [MODE_W-1:0] {
    MODE_HIT    = 3'd0,
    MODE_FILL   = 3'd1,
    MODE_VICTIM = 3'd2,
    MODE_EVICT  = 3'd3,
    MODE_DECAY  = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ALU_INC,
    ALU_DEC,
    ALU_MAX
  } alu_op_e;

  typedef struct packed {
    logic [1:0] y;
    logic       gt;
  } alu_res_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_EXEC,
    ST_FILL,
    ST_EVWR,
    ST_SCAN,
    ST_AGE,
    ST_DECAY,
    ST_DONE
  } state_e;

  function automatic logic [PC_W-1:0] pc_fold(input logic [PC_W-1:0] pc);
    return pc ^ (pc >> PC_FOLD_A) ^ (pc >> PC_FOLD_B);
  endfunction

endpackage

FILE: rtl/ssr_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module ssr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/ssr_rrip_alu.sv
// shared 2-bit unit: saturating increment and decrement, running maximum
// depends on ssr_pkg
module ssr_rrip_alu (
  input  ssr_pkg::alu_op_e  op_i,
  input  logic [1:0]        a_i,
  input  logic [1:0]        b_i,
  output ssr_pkg::alu_res_t res_o
);

  always_comb begin
    res_o.gt = (a_i > b_i);
    unique case (op_i)
      ssr_pkg::ALU_INC: res_o.y = (a_i == 2'd3) ? a_i : a_i + 2'd1;
      ssr_pkg::ALU_DEC: res_o.y = (a_i == 2'd0) ? a_i : a_i - 2'd1;
      ssr_pkg::ALU_MAX: res_o.y = (a_i > b_i) ? a_i : b_i;
      default:          res_o.y = a_i;
    endcase
  end

endmodule

FILE: rtl/ship_srrip_stream_replacement.sv
// srrip replacement engine with signature reuse counters and stride detection
// depends on ssr_pkg, ssr_ram, ssr_rrip_alu
//
// channel   dir  beat contents (lsb first)
// s_axis    in   mode[2:0] set_index[13:3] way_index[17:14] address pc, zero pad
// m_axis    out  victim_way[3:0] victim_valid[4], zero pad
//
// one beat at a time: fold set_index into range by reciprocal multiply, then read and
// execute; hit, unknown mode, fill to an invalid way and eviction without training go
// straight to done; fill and training eviction write back first; victim query scans
// the ways through the shared unit, then ages the set; decay sweeps the counter ram
// after reset a clearing pass over max(NUM_SETS, 2^SIG_BITS) entries holds tready low
// a waiting result does not block the next input beat; done holds while the output
// register is full and m_axis_tready is low
module ship_srrip_stream_replacement #(
  parameter int NUM_SETS  = 2048,
  parameter int NUM_WAYS  = 16,
  parameter int SIG_BITS  = 6,
  parameter int ADDR_BITS = 48,
  localparam int IN_BITS  = ssr_pkg::MODE_W + ssr_pkg::SET_IN_W + ssr_pkg::WAY_IN_W
                            + ADDR_BITS + ssr_pkg::PC_W,
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // mode, set_index, way_index, address, pc
  input  logic [IN_W-1:0]           s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // victim_way, victim_valid
  output logic [ssr_pkg::OUT_W-1:0] m_axis_tdata
);

  localparam int SET_W    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_W    = $clog2(NUM_WAYS);
  localparam int SIG_N    = 1 << SIG_BITS;
  localparam int CLR_N    = (NUM_SETS > SIG_N) ? NUM_SETS : SIG_N;
  localparam int CLR_W    = $clog2(CLR_N);
  localparam int RCP_SH   = ssr_pkg::SET_IN_W + $clog2(NUM_SETS);
  localparam int RCP_W    = ssr_pkg::SET_IN_W + 2;
  localparam int PROD_W   = ssr_pkg::SET_IN_W + RCP_W;
  localparam int RCP_M    = ((1 << RCP_SH) + NUM_SETS - 1) / NUM_SETS;
  localparam logic [ssr_pkg::SET_IN_W-1:0] NSETS_LO = ssr_pkg::SET_IN_W'(NUM_SETS);
  localparam int SET_LSB  = ssr_pkg::MODE_W;
  localparam int WAY_LSB  = SET_LSB + ssr_pkg::SET_IN_W;
  localparam int ADDR_LSB = WAY_LSB + ssr_pkg::WAY_IN_W;
  localparam int PC_LSB   = ADDR_LSB + ADDR_BITS;

  typedef struct packed {
    logic [1:0]                         scount;
    logic [ADDR_BITS-1:0]               pdelta;
    logic [ADDR_BITS-1:0]               paddr;
    logic [NUM_WAYS-1:0][SIG_BITS-1:0]  sig;
    logic [NUM_WAYS-1:0][1:0]           rrpv;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  ssr_pkg::state_e state_q, state_d;

  logic [CLR_W-1:0]        clr_q;
  logic                    mod_cnt_q;
  logic [SIG_BITS:0]       dec_q;
  logic [WAY_W-1:0]        scan_q;
  logic [ssr_pkg::MODE_W-1:0] mode_q;
  logic [ssr_pkg::SET_IN_W-1:0] set_in_q;
  logic [ssr_pkg::SET_IN_W-1:0] quo_q;
  logic [ssr_pkg::SET_IN_W-1:0] rem_q;
  logic [WAY_W-1:0]        way_q;
  logic                    way_ok_q;
  logic [ADDR_BITS-1:0]    addr_q;
  logic [SIG_BITS-1:0]     sig_q;
  logic [ADDR_BITS-1:0]    delta_q;
  logic                    match_q;
  logic [1:0]              top_q;
  logic [WAY_W-1:0]        victim_q;
  logic [SIG_BITS-1:0]     ev_sig_q;
  logic                    res_valid_q;
  logic [WAY_W-1:0]        res_way_q;
  logic                    m_tvalid_q;
  logic [ssr_pkg::OUT_W-1:0] m_tdata_q;

  logic                    set_we, set_re;
  logic [SET_W-1:0]        set_waddr, set_raddr;
  logic [ROW_W-1:0]        set_rdata;
  row_t                    rd_row, wr_row;
  logic                    cnt_we, cnt_re;
  logic [SIG_BITS-1:0]     cnt_waddr, cnt_raddr;
  logic [1:0]              cnt_wdata, cnt_rdata;
  ssr_pkg::alu_op_e        alu_op;
  logic [1:0]              alu_a, alu_b;
  ssr_pkg::alu_res_t       alu_res;

  logic                    in_beat, out_free, clr_last, scan_last, dec_end;
  logic [PROD_W-1:0]       quo_prod;
  logic [ADDR_BITS-1:0]    delta;
  logic [ssr_pkg::PC_W-1:0] pc_hash;
  logic [7:0]              way_ext, vic_ext;
  logic [1:0]              age;

  assign rd_row    = row_t'(set_rdata);
  assign in_beat   = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_tvalid_q || m_axis_tready;
  assign clr_last  = (clr_q == CLR_W'(CLR_N - 1));
  assign scan_last = (scan_q == WAY_W'(NUM_WAYS - 1));
  assign dec_end   = dec_q[SIG_BITS];
  assign quo_prod  = PROD_W'(set_in_q) * PROD_W'(RCP_M);
  assign delta     = addr_q - rd_row.paddr;
  assign pc_hash   = ssr_pkg::pc_fold(s_axis_tdata[PC_LSB +: ssr_pkg::PC_W]);
  assign way_ext   = 8'(s_axis_tdata[WAY_LSB +: ssr_pkg::WAY_IN_W]);
  assign vic_ext   = 8'(res_way_q);
  assign age       = ssr_pkg::RRPV_MAX - top_q;

  assign s_axis_tready = (state_q == ssr_pkg::ST_IDLE);
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

  ssr_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_set_ram (
    .clk_i   (clk_i),
    .we_i    (set_we),
    .waddr_i (set_waddr),
    .wdata_i (wr_row),
    .re_i    (set_re),
    .raddr_i (set_raddr),
    .rdata_o (set_rdata)
  );

  ssr_ram #(.WIDTH(2), .DEPTH(SIG_N)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (cnt_re),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  ssr_rrip_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ssr_pkg::ST_CLEAR: if (clr_last) state_d = ssr_pkg::ST_IDLE;
      ssr_pkg::ST_IDLE:  if (in_beat) state_d = ssr_pkg::ST_MOD;
      ssr_pkg::ST_MOD: begin
        if (mod_cnt_q) state_d = ssr_pkg::ST_READ;
      end
      ssr_pkg::ST_READ:  state_d = ssr_pkg::ST_EXEC;
      ssr_pkg::ST_EXEC: begin
        unique case (mode_q)
          ssr_pkg::MODE_FILL: begin
            state_d = way_ok_q ? ssr_pkg::ST_FILL : ssr_pkg::ST_DONE;
          end
          ssr_pkg::MODE_VICTIM: state_d = ssr_pkg::ST_SCAN;
          ssr_pkg::MODE_EVICT: begin
            state_d = (way_ok_q && rd_row.rrpv[way_q] == ssr_pkg::RRPV_MAX) ?
                      ssr_pkg::ST_EVWR : ssr_pkg::ST_DONE;
          end
          ssr_pkg::MODE_DECAY: state_d = ssr_pkg::ST_DECAY;
          default: state_d = ssr_pkg::ST_DONE;
        endcase
      end
      ssr_pkg::ST_FILL:  state_d = ssr_pkg::ST_DONE;
      ssr_pkg::ST_EVWR:  state_d = ssr_pkg::ST_DONE;
      ssr_pkg::ST_SCAN:  if (scan_last) state_d = ssr_pkg::ST_AGE;
      ssr_pkg::ST_AGE:   state_d = ssr_pkg::ST_DONE;
      ssr_pkg::ST_DECAY: if (dec_end) state_d = ssr_pkg::ST_DONE;
      ssr_pkg::ST_DONE:  if (out_free) state_d = ssr_pkg::ST_IDLE;
      default:           state_d = ssr_pkg::ST_CLEAR;
    endcase
  end

  // memory and shared unit controls
  always_comb begin
    set_we    = 1'b0;
    set_re    = 1'b0;
    set_waddr = SET_W'(rem_q);
    set_raddr = SET_W'(rem_q);
    wr_row    = rd_row;
    cnt_we    = 1'b0;
    cnt_re    = 1'b0;
    cnt_waddr = sig_q;
    cnt_raddr = sig_q;
    cnt_wdata = alu_res.y;
    alu_op    = ssr_pkg::ALU_DEC;
    alu_a     = cnt_rdata;
    alu_b     = top_q;
    unique case (state_q)
      ssr_pkg::ST_CLEAR: begin
        set_we    = ({1'b0, clr_q} < (CLR_W + 1)'(NUM_SETS));
        set_waddr = clr_q[SET_W-1:0];
        for (int i = 0; i < NUM_WAYS; i++) begin
          wr_row.rrpv[i] = ssr_pkg::RRPV_MAX;
          wr_row.sig[i]  = '0;
        end
        wr_row.paddr  = '0;
        wr_row.pdelta = '0;
        wr_row.scount = '0;
        cnt_we    = ({1'b0, clr_q} < (CLR_W + 1)'(SIG_N));
        cnt_waddr = clr_q[SIG_BITS-1:0];
        cnt_wdata = ssr_pkg::REUSE_INIT;
      end
      ssr_pkg::ST_READ: begin
        set_re = 1'b1;
        cnt_re = 1'b1;
      end
      ssr_pkg::ST_EXEC: begin
        if (mode_q == ssr_pkg::MODE_HIT && way_ok_q) begin
          alu_op              = ssr_pkg::ALU_INC;
          set_we              = 1'b1;
          wr_row.rrpv[way_q]  = '0;
          cnt_we              = 1'b1;
        end
        if (mode_q == ssr_pkg::MODE_EVICT) begin
          cnt_re    = 1'b1;
          cnt_raddr = rd_row.sig[way_q];
        end
      end
      ssr_pkg::ST_FILL: begin
        alu_op             = match_q ? ssr_pkg::ALU_INC : ssr_pkg::ALU_DEC;
        alu_a              = rd_row.scount;
        set_we             = 1'b1;
        wr_row.scount      = alu_res.y;
        wr_row.pdelta      = delta_q;
        wr_row.paddr       = addr_q;
        wr_row.sig[way_q]  = sig_q;
        wr_row.rrpv[way_q] = (alu_res.y[1] || cnt_rdata == '0) ? ssr_pkg::RRPV_MAX : '0;
      end
      ssr_pkg::ST_EVWR: begin
        cnt_we    = 1'b1;
        cnt_waddr = ev_sig_q;
      end
      ssr_pkg::ST_SCAN: begin
        alu_op = ssr_pkg::ALU_MAX;
        alu_a  = rd_row.rrpv[scan_q];
      end
      ssr_pkg::ST_AGE: begin
        set_we = 1'b1;
        for (int i = 0; i < NUM_WAYS; i++) begin
          wr_row.rrpv[i] = rd_row.rrpv[i] + age;
        end
      end
      ssr_pkg::ST_DECAY: begin
        cnt_re    = !dec_end;
        cnt_raddr = dec_q[SIG_BITS-1:0];
        cnt_we    = (dec_q != '0);
        cnt_waddr = SIG_BITS'(dec_q - 1'b1);
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ssr_pkg::ST_CLEAR;
      clr_q      <= '0;
      mod_cnt_q  <= 1'b0;
      dec_q      <= '0;
      scan_q     <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ssr_pkg::ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (state_q == ssr_pkg::ST_MOD) begin
        mod_cnt_q <= mod_cnt_q + 1'b1;
      end else begin
        mod_cnt_q <= 1'b0;
      end
      if (state_q == ssr_pkg::ST_DECAY) begin
        dec_q <= dec_q + 1'b1;
      end else begin
        dec_q <= '0;
      end
      if (state_q == ssr_pkg::ST_SCAN) begin
        scan_q <= scan_q + 1'b1;
      end else begin
        scan_q <= '0;
      end
      if (state_q == ssr_pkg::ST_DONE && out_free) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      mode_q      <= s_axis_tdata[ssr_pkg::MODE_W-1:0];
      set_in_q    <= s_axis_tdata[SET_LSB +: ssr_pkg::SET_IN_W];
      rem_q       <= '0;
      way_q       <= way_ext[WAY_W-1:0];
      way_ok_q    <= (way_ext < 8'(NUM_WAYS));
      addr_q      <= s_axis_tdata[ADDR_LSB +: ADDR_BITS];
      sig_q       <= pc_hash[SIG_BITS-1:0];
      res_valid_q <= 1'b0;
      res_way_q   <= '0;
    end
    // quotient first, remainder from the registered quotient in the next cycle
    if (state_q == ssr_pkg::ST_MOD) begin
      quo_q <= ssr_pkg::SET_IN_W'(quo_prod >> RCP_SH);
      rem_q <= set_in_q - quo_q * NSETS_LO;
    end
    if (state_q == ssr_pkg::ST_EXEC) begin
      delta_q  <= delta;
      match_q  <= (rd_row.pdelta != '0) && (delta == rd_row.pdelta);
      ev_sig_q <= rd_row.sig[way_q];
      top_q    <= '0;
      victim_q <= '0;
    end
    if (state_q == ssr_pkg::ST_SCAN && alu_res.gt) begin
      top_q    <= alu_res.y;
      victim_q <= scan_q;
    end
    if (state_q == ssr_pkg::ST_AGE) begin
      res_valid_q <= 1'b1;
      res_way_q   <= victim_q;
    end
    if (state_q == ssr_pkg::ST_DONE && out_free) begin
      m_tdata_q <= ssr_pkg::OUT_W'({res_valid_q, vic_ext[3:0]});
    end
  end

  a_beat_starts_fold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> state_q == ssr_pkg::ST_MOD)
    else $error("accepted beat did not start set folding");

  a_victim_holds_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ssr_pkg::ST_AGE |-> rd_row.rrpv[victim_q] == top_q)
    else $error("chosen victim way is not at the set maximum");

  a_cnt_ram_no_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_we && cnt_re) |-> cnt_waddr != cnt_raddr)
    else $error("counter ram read and write at one address");

  a_decay_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ssr_pkg::ST_DECAY |-> dec_q <= (SIG_BITS + 1)'(SIG_N))
    else $error("decay sweep ran past the counter table");

  a_result_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ssr_pkg::ST_DONE && m_tvalid_q && !m_axis_tready)
    |=> state_q == ssr_pkg::ST_DONE)
    else $error("result left while output register was full");

endmodule

FILE: test/tb.sv
// testbench for ship_srrip_stream_replacement: directed and random replacement events
// a scoreboard class tracks rrpv and signatures per way, stride state per set and reuse counters
// per signature; depends on ssr_pkg and the rtl of the engine
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SETS       = 2048;
  localparam int NUM_WAYS       = 16;
  localparam int SIG_BITS       = 6;
  localparam int ADDR_BITS      = 48;
  localparam int SIG_ENTRIES    = 1 << SIG_BITS;
  localparam int MODE_LAST      = (1 << ssr_pkg::MODE_W) - 1;
  localparam int TARGET_ITEMS   = 1300;
  localparam int HOT_SETS       = 4;
  localparam int PC_POOL        = 8;
  localparam int HOLD_AT        = 500;
  localparam int LONG_HOLD      = 400;
  localparam int BURST_FROM     = 800;
  localparam int BURST_TO       = 950;
  localparam int DRAIN_CYCLES   = 200;
  localparam int WATCHDOG_LIMIT = 10000;
  localparam int MAX_REPORTS    = 10;
  localparam logic [1:0] CTR_MAX   = 2'd3;
  localparam logic [1:0] STREAM_ON = 2'd2;

  typedef struct packed {
    logic [ssr_pkg::PC_W-1:0]     pc;
    logic [ADDR_BITS-1:0]         address;
    logic [ssr_pkg::WAY_IN_W-1:0] way;
    logic [ssr_pkg::SET_IN_W-1:0] set_idx;
    logic [ssr_pkg::MODE_W-1:0]   mode;
  } access_t;

  typedef struct packed {
    logic                         valid;
    logic [ssr_pkg::WAY_IN_W-1:0] way;
  } answer_t;

  localparam int IN_W = (($bits(access_t) + 7) / 8) * 8;

  class srrip_scoreboard;
    logic [1:0]           rrpv [NUM_SETS][NUM_WAYS];
    logic [SIG_BITS-1:0]  line_sig [NUM_SETS][NUM_WAYS];
    logic [1:0]           reuse [SIG_ENTRIES];
    logic [ADDR_BITS-1:0] seen_addr [NUM_SETS];
    logic [ADDR_BITS-1:0] seen_delta [NUM_SETS];
    logic [1:0]           stride_cnt [NUM_SETS];
    answer_t              pending_answers [$];
    int                   errors;

    function new();
      for (int s = 0; s < NUM_SETS; s++) begin
        for (int w = 0; w < NUM_WAYS; w++) begin
          rrpv[s][w]     = ssr_pkg::RRPV_MAX;
          line_sig[s][w] = '0;
        end
        seen_addr[s]  = '0;
        seen_delta[s] = '0;
        stride_cnt[s] = '0;
      end
      for (int i = 0; i < SIG_ENTRIES; i++) reuse[i] = ssr_pkg::REUSE_INIT;
      errors = 0;
    endfunction

    function answer_t note_access(access_t a);
      answer_t              ans;
      int                   s;
      int                   w;
      logic [SIG_BITS-1:0]  sig;
      logic [ADDR_BITS-1:0] delta;
      logic [1:0]           top;
      logic [1:0]           age;
      logic [SIG_BITS-1:0]  old_sig;
      bit                   found;
      s   = a.set_idx % NUM_SETS;
      w   = a.way;
      sig = a.pc[5:0] ^ a.pc[11:6] ^ a.pc[17:12];
      ans = '0;
      case (a.mode)
        ssr_pkg::MODE_HIT: begin
          rrpv[s][w] = '0;
          if (reuse[sig] < CTR_MAX) reuse[sig]++;
        end
        ssr_pkg::MODE_FILL: begin
          delta = a.address - seen_addr[s];
          if (seen_delta[s] != '0 && delta == seen_delta[s]) begin
            if (stride_cnt[s] < CTR_MAX) stride_cnt[s]++;
          end else if (stride_cnt[s] > 0) begin
            stride_cnt[s]--;
          end
          seen_delta[s]  = delta;
          seen_addr[s]   = a.address;
          line_sig[s][w] = sig;
          rrpv[s][w] = (stride_cnt[s] >= STREAM_ON || reuse[sig] == '0) ?
                       ssr_pkg::RRPV_MAX : 2'd0;
        end
        ssr_pkg::MODE_VICTIM: begin
          top = '0;
          for (int i = 0; i < NUM_WAYS; i++) if (rrpv[s][i] > top) top = rrpv[s][i];
          age = ssr_pkg::RRPV_MAX - top;
          for (int i = 0; i < NUM_WAYS; i++) rrpv[s][i] = rrpv[s][i] + age;
          found = 1'b0;
          for (int i = 0; i < NUM_WAYS; i++) begin
            if (!found && rrpv[s][i] == ssr_pkg::RRPV_MAX) begin
              ans.way = ssr_pkg::WAY_IN_W'(i);
              found   = 1'b1;
            end
          end
          ans.valid = 1'b1;
        end
        ssr_pkg::MODE_EVICT: begin
          if (rrpv[s][w] == ssr_pkg::RRPV_MAX) begin
            old_sig = line_sig[s][w];
            if (reuse[old_sig] > 0) reuse[old_sig]--;
          end
        end
        ssr_pkg::MODE_DECAY: begin
          for (int i = 0; i < SIG_ENTRIES; i++) if (reuse[i] > 0) reuse[i]--;
        end
        default: ;
      endcase
      pending_answers.push_back(ans);
      return ans;
    endfunction

    function void report_mismatch(string what, answer_t want, answer_t got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t %s: expected way %0d valid %0b, got way %0d valid %0b",
                 $time, what, want.way, want.valid, got.way, got.valid);
    endfunction

    function void check_answer(logic [ssr_pkg::OUT_W-1:0] data);
      answer_t got;
      answer_t want;
      got = data[$bits(answer_t)-1:0];
      if (pending_answers.size() == 0) begin
        report_mismatch("result with no access waiting", '0, got);
        return;
      end
      want = pending_answers.pop_front();
      if (got.way !== want.way) report_mismatch("victim_way", want, got);
      if (got.valid !== want.valid) report_mismatch("victim_valid", want, got);
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni        = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata  = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [ssr_pkg::OUT_W-1:0] m_axis_tdata;

  srrip_scoreboard sb;
  answer_t         last_answer;
  int              handled_items = 0;
  int              quiet_cycles  = 0;
  bit              hold_req      = 1'b0;
  bit              no_idle       = 1'b0;

  logic [ssr_pkg::SET_IN_W-1:0] hot_set [HOT_SETS];
  logic [ADDR_BITS-1:0]         stream_addr [HOT_SETS];
  logic [ADDR_BITS-1:0]         stream_stride [HOT_SETS];
  logic [ssr_pkg::PC_W-1:0]     pc_pool [PC_POOL];

  ship_srrip_stream_replacement #(
    .NUM_SETS (NUM_SETS),
    .NUM_WAYS (NUM_WAYS),
    .SIG_BITS (SIG_BITS),
    .ADDR_BITS(ADDR_BITS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [ADDR_BITS-1:0] rand_addr();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[ADDR_BITS-1:0];
  endfunction

  function automatic logic [ADDR_BITS-1:0] rand_stride();
    if ($urandom_range(0, 1) == 0) return ADDR_BITS'($urandom_range(1, 64) * 64);
    return rand_addr();
  endfunction

  function automatic logic [ssr_pkg::PC_W-1:0] pick_pc();
    if ($urandom_range(0, 4) == 0) return ssr_pkg::PC_W'($urandom);
    return pc_pool[$urandom_range(0, PC_POOL - 1)];
  endfunction

  task automatic issue(input logic [ssr_pkg::MODE_W-1:0] mode,
                       input logic [ssr_pkg::SET_IN_W-1:0] set_idx,
                       input logic [ssr_pkg::WAY_IN_W-1:0] way,
                       input logic [ADDR_BITS-1:0] address,
                       input logic [ssr_pkg::PC_W-1:0] pc);
    access_t a;
    int      gap;
    a   = '{pc: pc, address: address, way: way, set_idx: set_idx, mode: mode};
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'(a);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    last_answer = sb.note_access(a);
    if (mode <= ssr_pkg::MODE_DECAY) handled_items++;
    if (handled_items == HOLD_AT) hold_req = 1'b1;
    no_idle = handled_items >= BURST_FROM && handled_items < BURST_TO;
  endtask

  task automatic random_episode();
    int                           pick;
    int                           h;
    bit                           hot;
    logic [ssr_pkg::SET_IN_W-1:0] s;
    logic [ssr_pkg::WAY_IN_W-1:0] victim;
    logic [ADDR_BITS-1:0]         addr;
    pick = $urandom_range(0, 99);
    h    = $urandom_range(0, HOT_SETS - 1);
    hot  = $urandom_range(0, 4) != 0;
    s    = hot ? hot_set[h] : ssr_pkg::SET_IN_W'($urandom);
    if ($urandom_range(0, 49) == 0) begin
      pc_pool[$urandom_range(0, PC_POOL - 1)] = ssr_pkg::PC_W'($urandom);
    end
    if (pick < 45) begin
      // miss: query victim, train on it, refill the same way
      issue(ssr_pkg::MODE_VICTIM, s, ssr_pkg::WAY_IN_W'($urandom), rand_addr(),
            ssr_pkg::PC_W'($urandom));
      victim = last_answer.way;
      issue(ssr_pkg::MODE_EVICT, s, victim, rand_addr(), ssr_pkg::PC_W'($urandom));
      if (hot && $urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 9) == 0) stream_stride[h] = rand_stride();
        stream_addr[h] = stream_addr[h] + stream_stride[h];
        addr = stream_addr[h];
      end else begin
        addr = rand_addr();
      end
      issue(ssr_pkg::MODE_FILL, s, victim, addr, pick_pc());
    end else if (pick < 75) begin
      issue(ssr_pkg::MODE_HIT, s, ssr_pkg::WAY_IN_W'($urandom), rand_addr(), pick_pc());
    end else if (pick < 80) begin
      issue(ssr_pkg::MODE_DECAY, ssr_pkg::SET_IN_W'($urandom), ssr_pkg::WAY_IN_W'($urandom),
            rand_addr(), ssr_pkg::PC_W'($urandom));
    end else if (pick < 90) begin
      issue(ssr_pkg::MODE_EVICT, s, ssr_pkg::WAY_IN_W'($urandom), rand_addr(), pick_pc());
    end else if (pick < 95) begin
      issue(ssr_pkg::MODE_VICTIM, s, ssr_pkg::WAY_IN_W'($urandom), rand_addr(),
            ssr_pkg::PC_W'($urandom));
    end else begin
      issue(ssr_pkg::MODE_W'($urandom_range(0, MODE_LAST)), ssr_pkg::SET_IN_W'($urandom),
            ssr_pkg::WAY_IN_W'($urandom), rand_addr(), ssr_pkg::PC_W'($urandom));
    end
  endtask

  initial begin : access_source
    logic [ADDR_BITS-1:0] same_addr;
    sb = new();
    for (int i = 0; i < HOT_SETS; i++) begin
      hot_set[i]       = ssr_pkg::SET_IN_W'($urandom);
      stream_addr[i]   = rand_addr();
      stream_stride[i] = rand_stride();
    end
    for (int i = 0; i < PC_POOL; i++) pc_pool[i] = ssr_pkg::PC_W'($urandom);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed
    issue(ssr_pkg::MODE_VICTIM, '0, '0, '0, '0);
    issue(ssr_pkg::MODE_HIT, '0, '0, '0, '0);
    issue(ssr_pkg::MODE_FILL, '1, '1, '1, '1);
    issue(ssr_pkg::MODE_VICTIM, '1, '0, '0, '0);
    issue(ssr_pkg::MODE_EVICT, '1, '1, '0, '0);
    issue(ssr_pkg::MODE_EVICT, '1, '0, '0, '0);
    for (int k = 1; k <= 4; k++) begin
      issue(ssr_pkg::MODE_FILL, 11'd5, ssr_pkg::WAY_IN_W'(k), ADDR_BITS'(k * 'h100), '0);
    end
    issue(ssr_pkg::MODE_FILL, 11'd5, 4'd5, '0, '0);
    issue(ssr_pkg::MODE_VICTIM, 11'd5, '0, '0, '0);
    issue(ssr_pkg::MODE_DECAY, '0, '0, '0, '0);
    issue(ssr_pkg::MODE_DECAY, '1, '1, '1, '1);
    issue(ssr_pkg::MODE_FILL, 11'd9, 4'd7, rand_addr(), '0);
    repeat (4) issue(ssr_pkg::MODE_HIT, 11'd9, 4'd7, '0, '0);
    same_addr = rand_addr();
    repeat (2) issue(ssr_pkg::MODE_FILL, 11'd9, 4'd8, same_addr, '0);
    issue(ssr_pkg::MODE_EVICT, 11'd9, 4'd8, '0, '0);
    for (int m = ssr_pkg::MODE_DECAY + 1; m <= MODE_LAST; m++)
      issue(ssr_pkg::MODE_W'(m), ssr_pkg::SET_IN_W'($urandom), ssr_pkg::WAY_IN_W'($urandom),
            rand_addr(), ssr_pkg::PC_W'($urandom));

    while (handled_items < TARGET_ITEMS) random_episode();
    s_axis_tvalid <= 1'b0;

    while (sb.pending_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_answers.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin : result_sink
    int stall;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        stall    = LONG_HOLD;
        hold_req = 1'b0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 4);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      sb.check_answer(m_axis_tdata);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

endmodule

FILE: sim.f
rtl/ssr_pkg.sv
rtl/ssr_ram.sv
rtl/ssr_rrip_alu.sv
rtl/ship_srrip_stream_replacement.sv
test/tb.sv
